@@ src/irpd_pkg.sv @@
// Shared types and constants of the infrared pulse-distance frame encoder.
package irpd_pkg;

    // Field widths
    localparam int UNIT_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int BIT_IDX_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_TDATA_W = 16;

    // Command queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Last bit index of a payload byte
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = BIT_IDX_W'(BYTE_W - 1);

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MARK  = 3'd0,
        CFG_LEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ZERO_SPACE   = 3'd3,
        CFG_ONE_SPACE    = 3'd4
    } cfg_idx_t;

    // Segment kinds on the output tuser
    typedef enum logic [1:0] {
        KIND_LEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_TRAILER = 2'd2
    } kind_t;

    // Timing registers
    typedef struct packed {
        logic [UNIT_W-1:0] leader_mark;
        logic [UNIT_W-1:0] leader_space;
        logic [UNIT_W-1:0] bit_mark;
        logic [UNIT_W-1:0] zero_space;
        logic [UNIT_W-1:0] one_space;
    } cfg_t;

    // One classified byte waiting to be sent
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic              has_leader;
        logic              has_trailer;
    } cmd_t;

    // One output segment
    typedef struct packed {
        logic [UNIT_W-1:0] mark;
        logic [UNIT_W-1:0] space;
        kind_t             kind;
        logic              last;
    } seg_t;

endpackage

@@ src/irpd_front.sv @@
// Input stage: accepts payload words and turns them into queued commands.
module irpd_front
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] payload_byte
    input  logic              s_tuser,   // [0] frame_first
    input  logic              s_tlast,   // frame_last
    output cmd_t              cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t cmd_reg;
    logic accept;

    // The holding register frees up whenever the queue takes its word.
    assign s_tready = !hold_valid_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Classify the word: leader and trailer requests go with the byte.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.payload     <= s_tdata;
            cmd_reg.has_leader  <= s_tuser;
            cmd_reg.has_trailer <= s_tlast;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = hold_valid_reg;

endmodule

@@ src/irpd_queue.sv @@
// Small command queue that decouples the input stage from the segment sequencer.
module irpd_queue
    import irpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t in_cmd,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t out_cmd,
    output logic out_valid,
    input  logic out_ready
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] head_reg;
    logic [QUEUE_AW-1:0] head_next;
    logic [QUEUE_AW-1:0] tail_reg;
    logic [QUEUE_AW-1:0] tail_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[head_reg];

    // Pointer and fill bookkeeping; pointers wrap naturally.
    always_comb
    begin
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= in_cmd;
        end
    end

endmodule

@@ src/irpd_back.sv @@
// Segment sequencer: walks the optional leader, eight data bits and optional trailer of each command.
module irpd_back
    import irpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // [5:0] mark_units, [11:6] space_units
    output logic [1:0]             m_tuser,  // [1:0] segment_kind
    output logic                   m_tlast   // run_last
);

    typedef enum logic [2:0] {
        PH_LEADER  = 3'b001,
        PH_DATA    = 3'b010,
        PH_TRAILER = 3'b100
    } phase_t;

    logic                 busy_reg;
    logic                 busy_next;
    phase_t               phase_reg;
    phase_t               phase_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg;
    logic [BIT_IDX_W-1:0] bit_idx_next;
    cmd_t                 cur_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    seg_t                 seg_reg;
    seg_t                 seg;
    logic                 advance;
    logic                 emit;
    logic                 load;

    // The output register is free when empty or being taken.
    assign advance = !out_valid_reg || m_tready;
    assign emit    = advance && busy_reg;
    // Take the next command when idle or on the final segment of this one.
    assign load    = advance && cmd_valid && (!busy_reg || seg.last);
    assign cmd_ready = load;

    // Segment for the current position
    always_comb
    begin
        seg.mark  = cfg.bit_mark;
        seg.space = cur_reg.payload[bit_idx_reg] ? cfg.one_space : cfg.zero_space;
        seg.kind  = KIND_DATA;
        seg.last  = (bit_idx_reg == LAST_BIT_IDX) && !cur_reg.has_trailer;
        case (phase_reg)
            PH_LEADER:
            begin
                seg.mark  = cfg.leader_mark;
                seg.space = cfg.leader_space;
                seg.kind  = KIND_LEADER;
                seg.last  = 1'b0;
            end
            PH_DATA:
            begin
                seg.kind = KIND_DATA;
            end
            PH_TRAILER:
            begin
                seg.space = '0;
                seg.kind  = KIND_TRAILER;
                seg.last  = 1'b1;
            end
            default:
            begin
                seg.kind = KIND_DATA;
            end
        endcase
    end

    // Position bookkeeping
    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
        end
        if (emit)
        begin
            case (phase_reg)
                PH_LEADER:
                begin
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    bit_idx_next = bit_idx_reg + 1'b1;
                    if (bit_idx_reg == LAST_BIT_IDX)
                    begin
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    phase_next = PH_DATA;
                end
                default:
                begin
                    phase_next = PH_DATA;
                end
            endcase
            if (seg.last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next    = 1'b1;
            phase_next   = cmd.has_leader ? PH_LEADER : PH_DATA;
            bit_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_DATA;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= cmd;
        end
        if (emit)
        begin
            seg_reg <= seg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2 * UNIT_W){1'b0}}, seg_reg.space, seg_reg.mark};
    assign m_tuser  = seg_reg.kind;
    assign m_tlast  = seg_reg.last;

endmodule

@@ src/ir_pulse_distance_frame_encoder.sv @@
// Top level of the infrared pulse-distance frame encoder.
//
//   Channel  Direction  Word contents
//   s_*      in         tdata[7:0] payload byte, tuser frame first, tlast frame last
//   m_*      out        tdata[5:0] mark, [11:6] space, tuser kind, tlast run last
//   cfg_*    in         write enable, 3-bit register index, 6-bit value
//
// Each byte gives eight to ten segments, one per cycle from the sequencer while the
// output is not stalled.
// Input words pass through a holding register and a two-word queue, so the input
// keeps accepting while the output is stalled until both are full.
// Reset clears all control state and loads the timing registers with their defaults.
module ir_pulse_distance_frame_encoder
    import irpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] payload_byte
    input  logic                   s_tuser,   // [0] frame_first
    input  logic                   s_tlast,   // frame_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] mark_units, [11:6] space_units
    output logic [1:0]             m_tuser,   // [1:0] segment_kind
    output logic                   m_tlast,   // run_last
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [UNIT_W-1:0]      cfg_data
);

    cfg_t cfg_reg;
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_mark  <= UNIT_W'(16);
            cfg_reg.leader_space <= UNIT_W'(8);
            cfg_reg.bit_mark     <= UNIT_W'(1);
            cfg_reg.zero_space   <= UNIT_W'(1);
            cfg_reg.one_space    <= UNIT_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEADER_MARK:  cfg_reg.leader_mark  <= cfg_data;
                CFG_LEADER_SPACE: cfg_reg.leader_space <= cfg_data;
                CFG_BIT_MARK:     cfg_reg.bit_mark     <= cfg_data;
                CFG_ZERO_SPACE:   cfg_reg.zero_space   <= cfg_data;
                CFG_ONE_SPACE:    cfg_reg.one_space    <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    irpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    irpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (queue_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    irpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the infrared pulse-distance frame encoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    localparam int NUM_REGS     = 5;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 68;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_PAD    = 4;
    localparam int END_PAD      = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_SHOWN    = 10;

    // Register indexes past the end of the list; writes to them are ignored
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Timing settings whose segments can be read off directly
    localparam cfg_t TIMING_DEFAULT = '{6'd16, 6'd8, 6'd1, 6'd1, 6'd3};
    localparam cfg_t TIMING_ZERO    = '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
    localparam cfg_t TIMING_FULL    = '{6'd63, 6'd63, 6'd63, 6'd63, 6'd63};
    localparam cfg_t TIMING_UNIT    = '{6'd1, 6'd1, 6'd1, 6'd1, 6'd1};

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [UNIT_W-1:0]    value;
        logic [BYTE_W-1:0]    payload;
        logic                 first;
        logic                 last;
        logic                 typed;
        cfg_t                 timing;
    } dir_row_t;

    localparam int DIR_ROWS = 35;

    // Directed stimulus; typed rows carry the timing their segments must show
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{ROW_WORD, 3'd0, 6'd0, 8'h00, 1'b1, 1'b0, 1'b1, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b0, 1'b0, 1'b1, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h00, 1'b0, 1'b1, 1'b1, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h01, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h80, 1'b1, 1'b1, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h5A, 1'b1, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hA5, 1'b0, 1'b1, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, IDX_SPARE_LO, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, IDX_SPARE_HI, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1, TIMING_DEFAULT},
        '{ROW_REG, CFG_LEADER_MARK, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_LEADER_SPACE, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_BIT_MARK, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ZERO_SPACE, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ONE_SPACE, 6'd0, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h00, 1'b1, 1'b1, 1'b1, TIMING_ZERO},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1, TIMING_ZERO},
        '{ROW_REG, CFG_LEADER_MARK, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_LEADER_SPACE, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_BIT_MARK, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ZERO_SPACE, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ONE_SPACE, 6'd63, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h00, 1'b1, 1'b1, 1'b1, TIMING_FULL},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1, TIMING_FULL},
        '{ROW_WORD, 3'd0, 6'd0, 8'h3C, 1'b1, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hC3, 1'b0, 1'b1, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_LEADER_MARK, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_LEADER_SPACE, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_BIT_MARK, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ZERO_SPACE, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_REG, CFG_ONE_SPACE, 6'd1, 8'h00, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h00, 1'b1, 1'b1, 1'b1, TIMING_UNIT},
        '{ROW_WORD, 3'd0, 6'd0, 8'hFF, 1'b1, 1'b1, 1'b1, TIMING_UNIT},
        '{ROW_WORD, 3'd0, 6'd0, 8'h69, 1'b0, 1'b0, 1'b0, TIMING_DEFAULT}
    };

    // A word on offer: whether its segments come from a typed timing
    typedef struct {
        logic typed;
        cfg_t timing;
    } offered_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [UNIT_W-1:0]      cfg_data;

    cfg_t          timing_shadow;
    seg_t          segment_q [$];
    offered_word_t offered_q [$];

    int err_cnt;
    int idle_cycles;
    int word_cnt;
    int seg_cnt;
    int reg_wr_cnt;
    int burst_left;
    int hold_reqs;
    int holds_done;

    ir_pulse_distance_frame_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Number of segments that one byte gives
    function automatic int segment_count(input logic first, input logic last);
        return BYTE_W + (first ? 1 : 0) + (last ? 1 : 0);
    endfunction

    // Segment k of the run that one byte gives under the timing c
    function automatic seg_t segment_at(input cfg_t c, input logic [BYTE_W-1:0] payload,
                                        input logic first, input logic last, input int k);
        seg_t s;
        int   bit_pos;
        bit_pos = k - (first ? 1 : 0);
        if (first && k == 0)
        begin
            s.mark  = c.leader_mark;
            s.space = c.leader_space;
            s.kind  = KIND_LEADER;
        end
        else if (bit_pos == BYTE_W)
        begin
            s.mark  = c.bit_mark;
            s.space = '0;
            s.kind  = KIND_TRAILER;
        end
        else
        begin
            s.mark  = c.bit_mark;
            s.space = payload[bit_pos] ? c.one_space : c.zero_space;
            s.kind  = KIND_DATA;
        end
        s.last = (k == segment_count(first, last) - 1);
        return s;
    endfunction

    // Count a failure; only the first few are described
    task automatic note_failure(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
        begin
            $display("%s", msg);
        end
    endtask

    // Check each output word, predict the run of each input word, track the timing
    always @(posedge clk)
    begin : monitor
        seg_t          got;
        seg_t          want;
        offered_word_t ow;
        cfg_t          timing;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.mark  = m_tdata[UNIT_W-1:0];
                got.space = m_tdata[2*UNIT_W-1:UNIT_W];
                got.kind  = kind_t'(m_tuser);
                got.last  = m_tlast;
                if (segment_q.size() == 0)
                begin
                    note_failure($sformatf("Unexpected segment: mark %0d space %0d kind %0d last %0d",
                                           got.mark, got.space, got.kind, got.last));
                end
                else
                begin
                    want = segment_q.pop_front();
                    seg_cnt++;
                    if (got !== want || m_tdata[OUT_TDATA_W-1:2*UNIT_W] !== '0)
                    begin
                        note_failure($sformatf({"Segment mismatch: expected mark %0d space %0d ",
                                                "kind %0d last %0d, got mark %0d space %0d ",
                                                "kind %0d last %0d pad %h"},
                                               want.mark, want.space, want.kind, want.last,
                                               got.mark, got.space, got.kind, got.last,
                                               m_tdata[OUT_TDATA_W-1:2*UNIT_W]));
                    end
                end
            end
            if (s_tvalid && s_tready && offered_q.size() != 0)
            begin
                ow = offered_q.pop_front();
                timing = ow.typed ? ow.timing : timing_shadow;
                for (int k = 0; k < segment_count(s_tuser, s_tlast); k++)
                begin
                    segment_q.push_back(segment_at(timing, s_tdata, s_tuser, s_tlast, k));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEADER_MARK:  timing_shadow.leader_mark  = cfg_data;
                    CFG_LEADER_SPACE: timing_shadow.leader_space = cfg_data;
                    CFG_BIT_MARK:     timing_shadow.bit_mark     = cfg_data;
                    CFG_ZERO_SPACE:   timing_shadow.zero_space   = cfg_data;
                    CFG_ONE_SPACE:    timing_shadow.one_space    = cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: a rotating ready pattern, with long hold-offs on request
    initial
    begin : receiver
        logic [15:0] pattern;
        int          stretch;
        int          hold_left;
        m_tready  = 1'b0;
        pattern   = '1;
        stretch   = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < hold_reqs)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(16, 160);
                    pattern = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
                end
                m_tready = pattern[0];
                pattern  = {pattern[0], pattern[15:1]};
                stretch--;
            end
        end
    end

    // Offer one input word, in bursts with random gaps; starts and ends at a falling edge
    task automatic send_word(input logic [BYTE_W-1:0] payload, input logic first,
                             input logic last, input logic typed, input cfg_t timing);
        offered_word_t ow;
        int            gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        ow.typed  = typed;
        ow.timing = timing;
        offered_q.push_back(ow);
        s_tvalid = 1'b1;
        s_tdata  = payload;
        s_tuser  = first;
        s_tlast  = last;
        do
        begin
            @(posedge clk);
        end
        while (!(s_tvalid && s_tready));
        word_cnt++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected segment has come out
    task automatic drain;
        s_tvalid = 1'b0;
        while (segment_q.size() != 0 || offered_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    // One register write, issued at a falling edge while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNIT_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_wr_cnt++;
    endtask

    // Main sequence: reset, directed table, then random phases with new timings
    initial
    begin
        logic [UNIT_W-1:0] vals [NUM_REGS];
        int                sent;
        int                flen;
        logic              hold_asked;
        logic              pause_done;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        timing_shadow = TIMING_DEFAULT;
        err_cnt       = 0;
        idle_cycles   = 0;
        word_cnt      = 0;
        seg_cnt       = 0;
        reg_wr_cnt    = 0;
        burst_left    = 0;
        hold_reqs     = 0;
        holds_done    = 0;
        hold_asked    = 1'b0;
        pause_done    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_REG)
            begin
                drain();
                write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value);
            end
            else
            begin
                send_word(DIRECTED_ROWS[r].payload, DIRECTED_ROWS[r].first,
                          DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].timing);
            end
        end

        // Random part: mostly well-formed frames with random bytes, some loose words
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            for (int i = 0; i < NUM_REGS; i++)
            begin
                case (p)
                    0:       vals[i] = TIMING_DEFAULT[(NUM_REGS-1-i)*UNIT_W +: UNIT_W];
                    2:       vals[i] = TIMING_FULL[(NUM_REGS-1-i)*UNIT_W +: UNIT_W];
                    3:       vals[i] = ($urandom_range(0, 2) == 0) ? '0
                                       : UNIT_W'($urandom_range(1, 63));
                    default: vals[i] = UNIT_W'($urandom_range(1, 63));
                endcase
                write_reg(cfg_idx_t'(i), vals[i]);
            end
            if (p == 4)
            begin
                write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 7)), UNIT_W'($urandom));
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_word(BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, TIMING_DEFAULT);
                    sent++;
                end
                else
                begin
                    flen = $urandom_range(1, 6);
                    for (int j = 0; j < flen; j++)
                    begin
                        send_word(BYTE_W'($urandom), j == 0, j == flen - 1, 1'b0,
                                  TIMING_DEFAULT);
                        sent++;
                    end
                end
                // Long output stall while words keep coming
                if (p == 2 && !hold_asked && sent >= 20)
                begin
                    hold_reqs++;
                    hold_asked = 1'b1;
                end
                // Sender pause until the output has caught up
                if (p == 3 && !pause_done && sent >= 30)
                begin
                    drain();
                    pause_done = 1'b1;
                end
            end
        end

        // Closing: wait for the last segments, then a quiet stretch
        drain();
        repeat (END_PAD) @(negedge clk);
        if (segment_q.size() != 0)
        begin
            note_failure($sformatf("%0d expected segments never arrived", segment_q.size()));
        end
        $display("Summary: %0d input words, %0d segments checked, %0d register writes.",
                 word_cnt, seg_cnt, reg_wr_cnt);
        $display("Summary: all flag combinations, zero and full-scale timings, spare indexes, %s",
                 "long output stall and sender pause.");
        if (err_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("Failures: %0d", err_cnt);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ ir_pulse_distance_frame_encoder.f @@
src/irpd_pkg.sv
src/irpd_front.sv
src/irpd_queue.sv
src/irpd_back.sv
src/ir_pulse_distance_frame_encoder.sv
verif/tb.sv
